// ===== rtl/pdq_pkg.sv =====
// Shared types and constants for the priority deque with sort.
package pdq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ID_W   = 16;
    localparam int NAME_W = 64;
    localparam int MODE_W = 3;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 16;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 3'd0,
        MODE_POP_HEAD = 3'd1,
        MODE_POP_TAIL = 3'd2,
        MODE_CLEAR    = 3'd3,
        MODE_SORT     = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        CFG_MIN_ID = 1'b0,
        CFG_MAX_ID = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NAME_W-1:0] name;
    } entry_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_SHR,
        OP_SHL,
        OP_LOAD,
        OP_SORT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     lead;
    } cell_ctrl_t;

endpackage

// ===== rtl/pdq_if.sv =====
// Request and response channel interfaces of the priority deque.
interface pdq_cmd_if import pdq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   entry_id;
    logic [NAME_W-1:0] entry_name;
    logic              priority_req;

    modport source (output valid, mode, entry_id, entry_name, priority_req, input ready);
    modport sink   (input valid, mode, entry_id, entry_name, priority_req, output ready);
endinterface

interface pdq_rsp_if import pdq_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [ID_W-1:0]   removed_id;
    logic [NAME_W-1:0] removed_name;
    logic [CNT_W-1:0]  entry_count;
    logic [ID_W-1:0]   front_id;
    logic [NAME_W-1:0] front_name;

    modport source (output valid, status, removed_id, removed_name, entry_count,
                    front_id, front_name, input ready);
    modport sink   (input valid, status, removed_id, removed_name, entry_count,
                    front_id, front_name, output ready);
endinterface

// ===== rtl/pdq_cell.sv =====
// One deque slot: holds an entry, shifts with its neighbors, compare-swaps when sorting.
module pdq_cell import pdq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     left,
    input  entry_t     right,
    input  entry_t     load,
    input  logic       swap_in,
    output entry_t     data,
    output logic       swap_out
);

    entry_t data_reg;
    entry_t data_next;

    // leader of a valid pair swaps with its right neighbor on a strict greater-than
    assign swap_out = ctrl.lead && (data_reg.id > right.id);
    assign data     = data_reg;

    always_comb
    begin
        case (ctrl.op)
            OP_SHR:  data_next = left;
            OP_SHL:  data_next = right;
            OP_LOAD: data_next = load;
            OP_SORT:
            begin
                if (swap_out)
                    data_next = right;
                else if (swap_in)
                    data_next = left;
                else
                    data_next = data_reg;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

// ===== rtl/priority_deque_with_sort.sv =====
// Top level of the priority deque with sort.
// Usage: requests arrive on cmd (valid/ready), one response per request leaves on rsp.
// Modes: add (tail, or head when priority_req is set), remove head, remove tail,
// clear, and ascending sort by id. Adds are checked against min_id/max_id, which
// are written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while the block is idle, as the block itself does not enforce it. Entries live
// in a row of DEPTH cells; cell 0 is always the head. Adds and head removals
// shift or load the row, and a tail removal only lowers the count. For every mode
// but sort, the response is registered and valid the cycle after the request is
// accepted. Adds, removals and clear sustain one request per cycle unless rsp
// stalls. Sort runs odd-even transposition passes across the row, one pass per
// cycle, count passes in all; cmd.ready is low meanwhile. A sort of an empty deque
// answers with STAT_EMPTY and does not sort. If rsp is stalled the response
// register holds and cmd.ready drops until the response is taken. Reset empties
// the deque, sets min_id to 0 and max_id to 65535, and drops rsp.valid.
module priority_deque_with_sort import pdq_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    pdq_cmd_if.sink          cmd,
    pdq_rsp_if.source        rsp,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic {ST_IDLE, ST_SORT} state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] sort_cnt_reg, sort_cnt_next;
    logic [ID_W-1:0]  min_reg, min_next;
    logic [ID_W-1:0]  max_reg, max_next;
    logic             rsp_valid_reg, rsp_valid_next;
    status_t          rsp_status_reg, rsp_status_next;
    entry_t           rsp_removed_reg, rsp_removed_next;
    logic [CNT_W-1:0] rsp_count_reg, rsp_count_next;
    entry_t           rsp_front_reg, rsp_front_next;

    entry_t           new_entry;
    entry_t           cell_q [DEPTH];
    logic             cell_swap [DEPTH];
    cell_ctrl_t       cell_ctrl [DEPTH];
    cell_op_t         bcast_op;
    logic             load_tail;
    logic             sorting;
    logic             accept;
    logic             in_range;
    logic             is_full;
    logic             is_empty;
    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] tail_idx;
    entry_t           front_sel;

    assign new_entry.id   = cmd.entry_id;
    assign new_entry.name = cmd.entry_name;

    assign cmd.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = cmd.valid && cmd.ready;

    assign in_range = (cmd.entry_id >= min_reg) && (cmd.entry_id <= max_reg);
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign cnt_m1   = count_reg - CNT_W'(1);
    assign tail_idx = cnt_m1[IDX_W-1:0];
    assign sorting  = (state_reg == ST_SORT) && (sort_cnt_reg != count_reg);

    // row of cells
    for (genvar k = 0; k < DEPTH; k++)
    begin : g_cell
        localparam logic [CNT_W-1:0] K  = CNT_W'(k);
        localparam logic [CNT_W-1:0] K1 = CNT_W'(k + 1);
        localparam logic             PAR = (k % 2) == 1;

        entry_t left_d;
        entry_t right_d;
        logic   swap_l;

        if (k == 0)
        begin : g_first
            assign left_d = new_entry;
            assign swap_l = 1'b0;
        end
        else
        begin : g_mid
            assign left_d = cell_q[k-1];
            assign swap_l = cell_swap[k-1];
        end

        if (k == DEPTH - 1)
        begin : g_last
            assign right_d = cell_q[k];
        end
        else
        begin : g_inner
            assign right_d = cell_q[k+1];
        end

        assign cell_ctrl[k].op   = (load_tail && (count_reg == K)) ? OP_LOAD : bcast_op;
        assign cell_ctrl[k].lead = sorting && (sort_cnt_reg[0] == PAR) && (K1 < count_reg);

        pdq_cell u_cell
        (
            .clk      (clk),
            .ctrl     (cell_ctrl[k]),
            .left     (left_d),
            .right    (right_d),
            .load     (new_entry),
            .swap_in  (swap_l),
            .data     (cell_q[k]),
            .swap_out (cell_swap[k])
        );
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        sort_cnt_next    = sort_cnt_reg;
        min_next         = min_reg;
        max_next         = max_reg;
        bcast_op         = OP_HOLD;
        load_tail        = 1'b0;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_removed_next = rsp_removed_reg;
        rsp_count_next   = rsp_count_reg;
        rsp_front_next   = rsp_front_reg;
        front_sel        = cell_q[0];

        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MIN_ID: min_next = cfg_wdata;
                CFG_MAX_ID: max_next = cfg_wdata;
                default:    ;
            endcase
        end

        if (state_reg == ST_SORT)
        begin
            if (sort_cnt_reg == count_reg)
            begin
                state_next       = ST_IDLE;
                rsp_valid_next   = 1'b1;
                rsp_status_next  = STAT_OK;
                rsp_removed_next = '0;
                rsp_count_next   = count_reg;
                rsp_front_next   = cell_q[0];
            end
            else
            begin
                bcast_op      = OP_SORT;
                sort_cnt_next = sort_cnt_reg + CNT_W'(1);
            end
        end
        else if (accept)
        begin
            rsp_valid_next   = 1'b1;
            rsp_status_next  = STAT_OK;
            rsp_removed_next = '0;
            case (mode_t'(cmd.mode))
                MODE_ADD:
                begin
                    if (!in_range)
                        rsp_status_next = STAT_RANGE;
                    else if (is_full)
                        rsp_status_next = STAT_FULL;
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (!is_empty && cmd.priority_req)
                        begin
                            bcast_op  = OP_SHR;
                            front_sel = new_entry;
                        end
                        else
                        begin
                            load_tail = 1'b1;
                            if (is_empty)
                                front_sel = new_entry;
                        end
                    end
                end
                MODE_POP_HEAD:
                begin
                    if (is_empty)
                        rsp_status_next = STAT_EMPTY;
                    else
                    begin
                        rsp_removed_next = cell_q[0];
                        count_next       = cnt_m1;
                        bcast_op         = OP_SHL;
                        front_sel        = cell_q[1];
                    end
                end
                MODE_POP_TAIL:
                begin
                    if (is_empty)
                        rsp_status_next = STAT_EMPTY;
                    else
                    begin
                        rsp_removed_next = cell_q[tail_idx];
                        count_next       = cnt_m1;
                    end
                end
                MODE_CLEAR:
                begin
                    count_next = '0;
                end
                MODE_SORT:
                begin
                    if (is_empty)
                        rsp_status_next = STAT_EMPTY;
                    else
                    begin
                        rsp_valid_next = 1'b0;
                        state_next     = ST_SORT;
                        sort_cnt_next  = '0;
                    end
                end
                default: ;
            endcase
            rsp_count_next = count_next;
            rsp_front_next = (count_next != '0) ? front_sel : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            sort_cnt_reg  <= '0;
            min_reg       <= '0;
            max_reg       <= '1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sort_cnt_reg  <= sort_cnt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_status_reg  <= rsp_status_next;
        rsp_removed_reg <= rsp_removed_next;
        rsp_count_reg   <= rsp_count_next;
        rsp_front_reg   <= rsp_front_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.removed_id   = rsp_removed_reg.id;
    assign rsp.removed_name = rsp_removed_reg.name;
    assign rsp.entry_count  = rsp_count_reg;
    assign rsp.front_id     = rsp_front_reg.id;
    assign rsp.front_name   = rsp_front_reg.name;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_no_req_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT) |-> !cmd.ready)
        else $error("request taken during sort");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.mode != MODE_SORT)) |=> rsp.valid)
        else $error("no response after request");

    a_sort_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SORT) && (sort_cnt_reg == count_reg))
            |=> ((state_reg == ST_IDLE) && rsp.valid))
        else $error("sort did not finish with a response");

    a_sort_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SORT) |=> $stable(count_reg))
        else $error("count changed during sort");

endmodule
